@@ src/scds_pkg.sv @@
// Shared types, key codes and display helpers for the settable clock display scanner.
// No dependencies; every module of the block imports this package.
package scds_pkg;

    // Scan geometry: six time digits plus one key-code position.
    localparam int          DIGITS    = 7;
    localparam int          POS_W     = 3;
    localparam int          HIST_N    = 4;
    localparam logic [15:0] TPS_RESET = 16'd960;

    // Time limits and reset values.
    localparam logic [5:0]  SEC_TOP    = 6'd59;
    localparam logic [5:0]  MIN_TOP    = 6'd59;
    localparam logic [5:0]  HOUR_TOP   = 6'd23;
    localparam logic [5:0]  SEC_RESET  = 6'd45;
    localparam logic [5:0]  MIN_RESET  = 6'd59;
    localparam logic [4:0]  HOUR_RESET = 5'd12;

    // Key codes as seen in the frame key mask.
    localparam logic [6:0] KEY_ENTER = 7'h01;
    localparam logic [6:0] KEY_ESC   = 7'h02;
    localparam logic [6:0] KEY_RIGHT = 7'h04;
    localparam logic [6:0] KEY_UP    = 7'h08;
    localparam logic [6:0] KEY_DOWN  = 7'h10;
    localparam logic [6:0] KEY_LEFT  = 7'h20;

    // Field being edited.
    typedef enum logic [1:0] {
        EDIT_NONE = 2'd0,
        EDIT_SEC  = 2'd1,
        EDIT_MIN  = 2'd2,
        EDIT_HOUR = 2'd3
    } edit_t;

    // Accepted key, passed from the key scanner to the clock.
    typedef struct packed {
        logic       valid;
        logic [6:0] code;
    } key_evt_t;

    // Clock state as shown on the display.
    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] minute;
        logic [4:0] hour;
        edit_t      edit;
        logic [6:0] shown_key;
    } disp_t;

    // Seven-segment pattern of one decimal digit.
    function automatic logic [7:0] seg_of(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'b00111111;
            4'd1:    s = 8'b00000110;
            4'd2:    s = 8'b01011011;
            4'd3:    s = 8'b01001111;
            4'd4:    s = 8'b01100110;
            4'd5:    s = 8'b01101101;
            4'd6:    s = 8'b01111101;
            4'd7:    s = 8'b00000111;
            4'd8:    s = 8'b01111111;
            4'd9:    s = 8'b01101111;
            default: s = 8'b00000000;
        endcase
        return s;
    endfunction

    // Tens digit of a six-bit value by a compare chain.
    function automatic logic [3:0] bcd_tens(input logic [5:0] v);
        logic [3:0] t;
        if (v >= 6'd60)
            t = 4'd6;
        else if (v >= 6'd50)
            t = 4'd5;
        else if (v >= 6'd40)
            t = 4'd4;
        else if (v >= 6'd30)
            t = 4'd3;
        else if (v >= 6'd20)
            t = 4'd2;
        else if (v >= 6'd10)
            t = 4'd1;
        else
            t = 4'd0;
        return t;
    endfunction

    // Ones digit: the value less ten times its tens digit.
    function automatic logic [3:0] bcd_ones(input logic [5:0] v);
        logic [5:0] t6;
        logic [5:0] prod;
        logic [5:0] rem;
        t6   = {2'b00, bcd_tens(v)};
        prod = (t6 << 3) + (t6 << 1);
        rem  = v - prod;
        return rem[3:0];
    endfunction

    // Count up or down by one with wrap at the field's top value.
    function automatic logic [5:0] step_wrap(input logic [5:0] v, input logic [5:0] top,
                                             input logic down);
        logic [5:0] r;
        if (down)
            r = (v == 6'd0 || v > top) ? top : v - 6'd1;
        else
            r = (v >= top) ? 6'd0 : v + 6'd1;
        return r;
    endfunction

endpackage

@@ src/scds_key_scan.sv @@
// Scan position counter, per-frame key mask and three-frame key debounce.
// Depends on scds_pkg for the key event type and scan geometry.
module scds_key_scan (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fire,
    input  logic                       key_sense,
    output logic [scds_pkg::POS_W-1:0] pos,
    output logic [6:0]                 sel,
    output scds_pkg::key_evt_t         key_evt
);
    import scds_pkg::*;

    logic [POS_W-1:0] digit_pos_reg;
    logic [POS_W-1:0] digit_pos_next;
    logic [6:0]       hist_reg  [HIST_N];
    logic [6:0]       hist_next [HIST_N];
    logic [6:0]       mask_now;
    logic             frame_end;

    // A stray position beyond the last digit scans as position zero.
    assign pos = (digit_pos_reg >= POS_W'(DIGITS)) ? '0 : digit_pos_reg;
    assign sel = 7'(1) << pos;

    // This beat's key line ORed into the frame being gathered.
    assign mask_now  = key_sense ? (hist_reg[0] | sel) : hist_reg[0];
    assign frame_end = (pos == POS_W'(DIGITS - 1));

    // A key is taken when it is non-zero, steady for three frames and new.
    always_comb
    begin
        key_evt.code  = mask_now;
        key_evt.valid = fire && frame_end && (mask_now != 7'd0) &&
                        (mask_now == hist_reg[1]) && (mask_now == hist_reg[2]) &&
                        (mask_now != hist_reg[3]);
    end

    // Next scan position and mask history.
    always_comb
    begin
        digit_pos_next = digit_pos_reg;
        for (int i = 0; i < HIST_N; i++)
        begin
            hist_next[i] = hist_reg[i];
        end
        if (fire)
        begin
            if (frame_end)
            begin
                digit_pos_next = '0;
                hist_next[3]   = hist_reg[2];
                hist_next[2]   = hist_reg[1];
                hist_next[1]   = mask_now;
                hist_next[0]   = 7'd0;
            end
            else
            begin
                digit_pos_next = pos + POS_W'(1);
                hist_next[0]   = mask_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_pos_reg <= '0;
            for (int i = 0; i < HIST_N; i++)
            begin
                hist_reg[i] <= 7'd0;
            end
        end
        else
        begin
            digit_pos_reg <= digit_pos_next;
            for (int i = 0; i < HIST_N; i++)
            begin
                hist_reg[i] <= hist_next[i];
            end
        end
    end

endmodule

@@ src/scds_clock.sv @@
// Time of day, run/stop and edit control, second prescaler and LED toggle.
// Depends on scds_pkg for key codes, the edit field type and wrap helpers.
module scds_clock (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               fire,
    input  scds_pkg::key_evt_t key_evt,
    output scds_pkg::disp_t    disp,
    output logic [5:0]         sec_next,
    output logic [5:0]         min_next,
    output logic [4:0]         hour_next,
    output logic               led_next
);
    import scds_pkg::*;

    logic [15:0] tps_reg;
    logic [15:0] tick_count_reg;
    logic [15:0] tick_count_next;
    logic [5:0]  sec_reg;
    logic [5:0]  min_reg;
    logic [4:0]  hour_reg;
    logic        stopped_reg;
    logic        stopped_next;
    edit_t       edit_reg;
    edit_t       edit_next;
    logic [6:0]  shown_key_reg;
    logic [6:0]  shown_key_next;
    logic        led_reg;
    logic [5:0]  sec_k;
    logic [5:0]  min_k;
    logic [4:0]  hour_k;
    logic [15:0] tc_dec;
    logic [6:0]  sec_inc;
    logic [6:0]  min_inc;
    logic [5:0]  hour_inc;
    logic        adj_down;

    // State before this beat feeds the display.
    assign disp = '{sec: sec_reg, minute: min_reg, hour: hour_reg,
                    edit: edit_reg, shown_key: shown_key_reg};

    assign adj_down = (key_evt.code == KEY_DOWN);
    assign tc_dec   = tick_count_reg - 16'd1;

    // Key action first, then the second tick on the updated state.
    always_comb
    begin
        stopped_next    = stopped_reg;
        edit_next       = edit_reg;
        shown_key_next  = shown_key_reg;
        sec_k           = sec_reg;
        min_k           = min_reg;
        hour_k          = hour_reg;
        tick_count_next = tick_count_reg;
        led_next        = led_reg;
        sec_inc         = 7'd0;
        min_inc         = 7'd0;
        hour_inc        = 6'd0;
        if (fire && key_evt.valid)
        begin
            shown_key_next = key_evt.code;
            case (key_evt.code)
                KEY_ESC:
                begin
                    if (!stopped_reg)
                    begin
                        stopped_next = 1'b1;
                        edit_next    = EDIT_SEC;
                    end
                end
                KEY_ENTER:
                begin
                    stopped_next = 1'b0;
                    edit_next    = EDIT_NONE;
                end
                KEY_LEFT:
                begin
                    if (edit_reg == EDIT_SEC)
                        edit_next = EDIT_MIN;
                    else if (edit_reg == EDIT_MIN)
                        edit_next = EDIT_HOUR;
                end
                KEY_RIGHT:
                begin
                    if (edit_reg == EDIT_HOUR)
                        edit_next = EDIT_MIN;
                    else if (edit_reg == EDIT_MIN)
                        edit_next = EDIT_SEC;
                end
                KEY_UP, KEY_DOWN:
                begin
                    if (stopped_reg)
                    begin
                        if (edit_reg == EDIT_SEC)
                            sec_k = step_wrap(sec_reg, SEC_TOP, adj_down);
                        else if (edit_reg == EDIT_MIN)
                            min_k = step_wrap(min_reg, MIN_TOP, adj_down);
                        else if (edit_reg == EDIT_HOUR)
                            hour_k = 5'(step_wrap({1'b0, hour_reg}, HOUR_TOP, adj_down));
                    end
                end
                default:
                begin
                    // Other codes are only shown.
                end
            endcase
        end
        sec_next  = sec_k;
        min_next  = min_k;
        hour_next = hour_k;
        if (fire)
        begin
            tick_count_next = tc_dec;
            if (tc_dec == 16'd0)
            begin
                tick_count_next = tps_reg;
                led_next        = ~led_reg;
                if (!stopped_next)
                begin
                    // Advance one second with carries into minutes and hours.
                    sec_inc = {1'b0, sec_k} + 7'd1;
                    if (sec_inc > 7'd59)
                    begin
                        sec_next = 6'd0;
                        min_inc  = {1'b0, min_k} + 7'd1;
                        if (min_inc > 7'd59)
                        begin
                            min_next = 6'd0;
                            hour_inc = {1'b0, hour_k} + 6'd1;
                            hour_next = (hour_inc > 6'd23) ? 5'd0 : hour_inc[4:0];
                        end
                        else
                        begin
                            min_next = min_inc[5:0];
                        end
                    end
                    else
                    begin
                        sec_next = sec_inc[5:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg        <= TPS_RESET;
            tick_count_reg <= TPS_RESET;
            sec_reg        <= SEC_RESET;
            min_reg        <= MIN_RESET;
            hour_reg       <= HOUR_RESET;
            stopped_reg    <= 1'b0;
            edit_reg       <= EDIT_NONE;
            shown_key_reg  <= 7'd0;
            led_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                tps_reg <= cfg_wr_data;
            tick_count_reg <= tick_count_next;
            sec_reg        <= sec_next;
            min_reg        <= min_next;
            hour_reg       <= hour_next;
            stopped_reg    <= stopped_next;
            edit_reg       <= edit_next;
            shown_key_reg  <= shown_key_next;
            led_reg        <= led_next;
        end
    end

endmodule

@@ src/scds_seg_mux.sv @@
// Segment pattern for the scanned position: BCD digits, edit mark or key code.
// Depends on scds_pkg for the display state type and digit decode helpers.
module scds_seg_mux (
    input  logic [scds_pkg::POS_W-1:0] pos,
    input  scds_pkg::disp_t            disp,
    output logic [7:0]                 segments
);
    import scds_pkg::*;

    logic [5:0] field_val;
    logic [3:0] digit;
    logic       marked;

    // Pick the time field for this digit pair.
    always_comb
    begin
        case (pos[2:1])
            2'd0:    field_val = disp.sec;
            2'd1:    field_val = disp.minute;
            2'd2:    field_val = {1'b0, disp.hour};
            default: field_val = 6'd0;
        endcase
    end

    // Odd positions are tens, even positions are ones.
    assign digit  = pos[0] ? bcd_tens(field_val) : bcd_ones(field_val);
    assign marked = (disp.edit != EDIT_NONE) && ((pos[2:1] + 2'd1) == disp.edit);

    // The last position shows the key code with no edit mark.
    always_comb
    begin
        if (pos >= POS_W'(DIGITS - 1))
            segments = {1'b0, disp.shown_key};
        else
            segments = {marked, 7'd0} | seg_of(digit);
    end

endmodule

@@ src/settable_clock_display_scanner.sv @@
// Top level of the settable clock display scanner: input register, result register.
// Depends on scds_pkg, scds_key_scan, scds_clock and scds_seg_mux.
//
//  Channel | Direction | Handshake              | Beat contents
//  --------+-----------+------------------------+--------------------------------------
//  in      | input     | in_valid / in_stall    | tick, key_sense
//  out     | output    | out_valid / out_stall  | segments, digit_select, led, time
//  cfg     | input     | cfg_wr_en              | cfg_wr_data (ticks per second)
//
// One beat is accepted per cycle while in_stall is low; a tick beat moves from the input
// register to the result register once that register can load, which makes its result valid.
// An idle poll beat leaves the input register without producing a result.
// Reset sets the time to 12:59:45, running, and clears the key history.
// A stalled result holds the input register, which stalls the input side.
module settable_clock_display_scanner (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        tick,
    input  logic        key_sense,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  segments,
    output logic [6:0]  digit_select,
    output logic        led,
    output logic [5:0]  seconds,
    output logic [5:0]  minutes,
    output logic [4:0]  hours
);
    import scds_pkg::*;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic             s1_tick_reg;
    logic             s1_key_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       segments_reg;
    logic [6:0]       digit_select_reg;
    logic             led_reg;
    logic [5:0]       seconds_reg;
    logic [5:0]       minutes_reg;
    logic [4:0]       hours_reg;
    logic             out_load;
    logic             s1_go;
    logic             fire;
    logic             in_take;
    logic [POS_W-1:0] pos;
    logic [6:0]       sel;
    key_evt_t         key_evt;
    disp_t            disp;
    logic [7:0]       seg_now;
    logic [5:0]       sec_next;
    logic [5:0]       min_next;
    logic [4:0]       hour_next;
    logic             led_next;

    // Handshake control between the two registers.
    assign out_load = !out_valid_reg || !out_stall;
    assign s1_go    = s1_valid_reg && (!s1_tick_reg || out_load);
    assign fire     = s1_valid_reg && s1_tick_reg && out_load;
    assign in_stall = s1_valid_reg && !s1_go;
    assign in_take  = in_valid && !in_stall;

    assign s1_valid_next  = in_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
    assign out_valid_next = fire ? 1'b1 : (out_load ? 1'b0 : out_valid_reg);

    // Key scanning and debounce.
    scds_key_scan u_key_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .key_sense (s1_key_reg),
        .pos       (pos),
        .sel       (sel),
        .key_evt   (key_evt)
    );

    // Timekeeping and editing.
    scds_clock u_clock (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .key_evt     (key_evt),
        .disp        (disp),
        .sec_next    (sec_next),
        .min_next    (min_next),
        .hour_next   (hour_next),
        .led_next    (led_next)
    );

    // Segment pattern from the state before this beat.
    scds_seg_mux u_seg_mux (
        .pos      (pos),
        .disp     (disp),
        .segments (seg_now)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_tick_reg <= tick;
            s1_key_reg  <= key_sense;
        end
        if (fire)
        begin
            segments_reg     <= seg_now;
            digit_select_reg <= sel;
            led_reg          <= led_next;
            seconds_reg      <= sec_next;
            minutes_reg      <= min_next;
            hours_reg        <= hour_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign segments     = segments_reg;
    assign digit_select = digit_select_reg;
    assign led          = led_reg;
    assign seconds      = seconds_reg;
    assign minutes      = minutes_reg;
    assign hours        = hours_reg;

    // A result always drives exactly one digit position.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot(digit_select))
    else $error("digit_select is not one-hot on a valid result");

    // The input side only stalls while a beat waits in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s1_tick_reg && out_valid_reg && out_stall))
    else $error("input stalled without a blocked tick beat");

    // Reported time stays within a day.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (seconds <= 6'd59 && minutes <= 6'd59 && hours <= 5'd23))
    else $error("time out of range");

    // A held result is not dropped while the result register is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(digit_select)))
    else $error("stalled result lost");

endmodule
